FILE: hdl/link_sender_backoff_admission_top_assert.svh
// Assertion macros for the link sender backoff and admission block.
// Used by link_sender_backoff_admission_top; expects clk and rst_n in scope.
`ifndef LINK_SENDER_BACKOFF_ADMISSION_TOP_ASSERT_SVH
`define LINK_SENDER_BACKOFF_ADMISSION_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define LSBA_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define LSBA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/lsba_pkg.sv
// Shared types and constants for the link sender backoff and admission block.
// No dependencies; imported by every module of the block.
package lsba_pkg;

    // Event codes of the request field func
    typedef enum logic [2:0] {
        FN_START      = 3'd0,
        FN_SEND       = 3'd1,
        FN_RETRY      = 3'd2,
        FN_DEADLINE   = 3'd3,
        FN_CONNECT    = 3'd4,
        FN_WRITE_DONE = 3'd5,
        FN_REPORT     = 3'd6,
        FN_SHUTDOWN   = 3'd7
    } func_t;

    // Link modes
    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_DOWN  = 3'd1,
        MODE_WAIT  = 3'd2,
        MODE_CONN  = 3'd3,
        MODE_HDR   = 3'd4,
        MODE_READY = 3'd5,
        MODE_SHUT  = 3'd6
    } mode_t;

    // Commands issued with a result
    typedef enum logic [2:0] {
        CMD_NONE     = 3'd0,
        CMD_CONNECT  = 3'd1,
        CMD_DATA     = 3'd2,
        CMD_HEADER   = 3'd3,
        CMD_TEARDOWN = 3'd4
    } cmd_t;

    // Configuration register indexes
    localparam int CFG_INDEX_BITS = 8;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PENDING_LIMIT = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_BACKOFF   = 8'd1;
    localparam int CFG_DATA_BITS = 24;

    // Field widths and reset values
    localparam int BYTE_BITS    = 24;
    localparam int DELAY_BITS   = 8;
    localparam int REPORT_BITS  = 32;
    localparam logic [BYTE_BITS-1:0]  PENDING_LIMIT_RST = 24'd65536;
    localparam logic [DELAY_BITS-1:0] MAX_BACKOFF_RST   = 8'd60;

    // Input request
    typedef struct packed {
        logic [2:0]           func;
        logic [BYTE_BITS-1:0] byte_count;
        logic                 had_error;
        logic                 socket_open;
        logic                 deadline_reached;
    } in_item_t;

    // Result request
    typedef struct packed {
        logic [2:0]             link_state;
        logic [2:0]             command;
        logic                   close_socket;
        logic                   arm_retry;
        logic [DELAY_BITS-1:0]  retry_delay_secs;
        logic [BYTE_BITS-1:0]   pending_total;
        logic                   report_valid;
        logic [REPORT_BITS-1:0] sent_total;
        logic [REPORT_BITS-1:0] dropped_total;
        logic [REPORT_BITS-1:0] failed_total;
        logic                   start_error;
    } out_item_t;

    // Next values of the link state registers
    typedef struct packed {
        mode_t                 mode;
        logic [DELAY_BITS-1:0] backoff;
        logic [BYTE_BITS-1:0]  pending;
    } link_next_t;

    // Byte counter controls
    typedef struct packed {
        logic add_sent;
        logic add_drop;
        logic add_fail;
        logic clear;
    } ctr_ctl_t;

    // Per-event result flags from the event decoder
    typedef struct packed {
        cmd_t                  command;
        logic                  close_socket;
        logic                  arm_retry;
        logic [DELAY_BITS-1:0] retry_delay_secs;
        logic                  report_valid;
        logic                  start_error;
    } evt_res_t;

endpackage

FILE: hdl/lsba_sat_ctr.sv
// Saturating byte counter with clear, width set by COUNTER_BITS.
// Depends on lsba_pkg for field widths.
module lsba_sat_ctr
    import lsba_pkg::*;
#(
    parameter int COUNTER_BITS = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   add,
    input  logic                   clear,
    input  logic [BYTE_BITS-1:0]   amount,
    output logic [REPORT_BITS-1:0] value
);

    localparam int SUM_BITS = ((COUNTER_BITS > BYTE_BITS) ? COUNTER_BITS : BYTE_BITS) + 1;

    logic [COUNTER_BITS-1:0] count_reg;
    logic [COUNTER_BITS-1:0] count_next;
    logic [SUM_BITS-1:0]     sum;
    logic [SUM_BITS-1:0]     max_ext;
    logic [COUNTER_BITS-1:0] sat_sum;

    // Add with clamp at the all-ones value
    assign sum     = SUM_BITS'(count_reg) + SUM_BITS'(amount);
    assign max_ext = SUM_BITS'({COUNTER_BITS{1'b1}});
    assign sat_sum = (sum > max_ext) ? {COUNTER_BITS{1'b1}} : sum[COUNTER_BITS-1:0];

    // Clear on report, else advance on add
    always_comb
    begin
        if (clear)
        begin
            count_next = '0;
        end
        else if (add)
        begin
            count_next = sat_sum;
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Report view is the low 32 bits, zero-extended when narrower
    assign value = REPORT_BITS'(count_reg);

endmodule

FILE: hdl/lsba_event.sv
// Event decoder: next link mode, backoff and pending count, plus result flags.
// Depends on lsba_pkg for event, mode and command codes.
module lsba_event
    import lsba_pkg::*;
(
    input  in_item_t              item,
    input  mode_t                 mode,
    input  logic [DELAY_BITS-1:0] backoff,
    input  logic [BYTE_BITS-1:0]  pending,
    input  logic [BYTE_BITS-1:0]  admit_limit,
    input  logic [DELAY_BITS-1:0] max_backoff,
    output link_next_t            link_next,
    output ctr_ctl_t              ctr_ctl,
    output evt_res_t              res
);

    func_t                 fn;
    logic                  is_shut;
    logic                  is_idle;
    logic                  active;
    logic                  fail;
    logic                  sched;
    logic [DELAY_BITS-1:0] cap;
    logic [DELAY_BITS:0]   dbl;
    logic [DELAY_BITS-1:0] backoff_dbl;
    logic [BYTE_BITS:0]    pend_sum;
    logic                  send_live;
    logic                  send_ok;
    logic [BYTE_BITS-1:0]  pend_sub;

    assign fn      = func_t'(item.func);
    assign is_shut = (mode == MODE_SHUT);
    assign is_idle = (mode == MODE_IDLE);
    assign active  = !is_shut && !is_idle;
    assign fail    = item.had_error || !item.socket_open;

    // Reconnect scheduling on an active link: after every failed connect, after a failed write
    // unless a retry is already waiting or connecting
    assign sched = active && fail &&
                   ((fn == FN_CONNECT) ||
                    ((fn == FN_WRITE_DONE) && (mode != MODE_WAIT) && (mode != MODE_CONN)));

    // Double the delay, clamp at the cap (a zero cap acts as one)
    assign cap         = (max_backoff == '0) ? DELAY_BITS'(1) : max_backoff;
    assign dbl         = {backoff, 1'b0};
    assign backoff_dbl = (dbl > {1'b0, cap}) ? cap : dbl[DELAY_BITS-1:0];

    // Send admission
    assign pend_sum  = {1'b0, pending} + {1'b0, item.byte_count};
    assign send_live = !is_shut && (item.byte_count != '0);
    assign send_ok   = send_live && (mode == MODE_READY) && (pend_sum <= {1'b0, admit_limit});

    // Lower pending on write completion, floor at zero
    assign pend_sub = (item.byte_count > pending) ? '0 : (pending - item.byte_count);

    // Next state of the link registers
    always_comb
    begin
        link_next.mode    = mode;
        link_next.backoff = backoff;
        link_next.pending = pending;
        unique case (fn)
            FN_START:
            begin
                if (is_idle)
                begin
                    link_next.mode = MODE_CONN;
                end
            end
            FN_SEND:
            begin
                if (send_ok)
                begin
                    link_next.pending = pend_sum[BYTE_BITS-1:0];
                end
            end
            FN_RETRY:
            begin
                if (active)
                begin
                    link_next.mode = MODE_CONN;
                end
            end
            FN_DEADLINE:
            begin
                link_next.mode = mode;
            end
            FN_CONNECT:
            begin
                if (sched)
                begin
                    link_next.mode    = MODE_WAIT;
                    link_next.backoff = backoff_dbl;
                end
                else if (active)
                begin
                    link_next.mode    = MODE_HDR;
                    link_next.backoff = DELAY_BITS'(1);
                end
            end
            FN_WRITE_DONE:
            begin
                if (active && fail)
                begin
                    link_next.pending = '0;
                    if (sched)
                    begin
                        link_next.mode    = MODE_WAIT;
                        link_next.backoff = backoff_dbl;
                    end
                end
                else if (active)
                begin
                    if (mode == MODE_HDR)
                    begin
                        link_next.mode = MODE_READY;
                    end
                    link_next.pending = pend_sub;
                end
            end
            FN_REPORT:
            begin
                link_next.mode = mode;
            end
            FN_SHUTDOWN:
            begin
                if (!is_shut)
                begin
                    link_next.mode = MODE_SHUT;
                end
            end
        endcase
    end

    // Result flags and counter controls
    always_comb
    begin
        res              = '0;
        res.command      = CMD_NONE;
        ctr_ctl          = '0;
        res.arm_retry    = sched;
        res.retry_delay_secs = sched ? backoff : '0;
        unique case (fn)
            FN_START:
            begin
                if (is_idle)
                begin
                    res.command = CMD_CONNECT;
                end
                else
                begin
                    res.start_error = 1'b1;
                end
            end
            FN_SEND:
            begin
                if (send_ok)
                begin
                    res.command = CMD_DATA;
                end
                else if (send_live)
                begin
                    ctr_ctl.add_drop = 1'b1;
                end
            end
            FN_RETRY:
            begin
                if (active)
                begin
                    res.command = CMD_CONNECT;
                end
            end
            FN_DEADLINE:
            begin
                if ((mode == MODE_CONN) || (mode == MODE_WAIT) || (mode == MODE_DOWN))
                begin
                    res.close_socket = item.deadline_reached;
                end
            end
            FN_CONNECT:
            begin
                if (active && !fail)
                begin
                    res.command = CMD_HEADER;
                end
            end
            FN_WRITE_DONE:
            begin
                if (active && fail)
                begin
                    ctr_ctl.add_fail = 1'b1;
                    res.close_socket = item.had_error;
                end
                else if (active)
                begin
                    ctr_ctl.add_sent = 1'b1;
                end
            end
            FN_REPORT:
            begin
                if (!is_shut)
                begin
                    res.report_valid = 1'b1;
                    ctr_ctl.clear    = 1'b1;
                end
            end
            FN_SHUTDOWN:
            begin
                if (!is_shut)
                begin
                    res.command      = CMD_TEARDOWN;
                    res.close_socket = item.socket_open;
                end
            end
        endcase
    end

endmodule

FILE: hdl/link_sender_backoff_admission_top.sv
// A request taken into the input register is decoded from it there, and its result is then
// registered in the result register; while out_stall is low, throughput is one per cycle.
// The link mode, backoff, pending count and counters update in the same cycle
// that a request leaves the input register, so requests run back to back.
// Reset (rst_n low, asynchronous): mode idle, backoff 1, pending and counters 0,
// byte limit 65536, max_backoff_secs 60, both pipeline stages empty.
`include "link_sender_backoff_admission_top_assert.svh"

module link_sender_backoff_admission_top
    import lsba_pkg::*;
#(
    parameter int COUNTER_BITS = 32
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    // Input requests
    input  logic                      in_valid,
    output logic                      in_stall,
    input  in_item_t                  in_data,
    // Result requests
    output logic                      out_valid,
    input  logic                      out_stall,
    output out_item_t                 out_data,
    // Configuration writes
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    logic                  s1_valid_reg;
    in_item_t              s1_item_reg;
    logic                  out_valid_reg;
    out_item_t             out_item_reg;
    out_item_t             out_item_next;
    logic                  out_free;
    logic                  advance;
    logic                  in_take;

    mode_t                 mode_reg;
    logic [DELAY_BITS-1:0] backoff_reg;
    logic [BYTE_BITS-1:0]  pending_reg;
    logic [BYTE_BITS-1:0]  limit_reg;
    logic [DELAY_BITS-1:0] max_backoff_reg;

    link_next_t            link_next;
    ctr_ctl_t              ctr_ctl;
    evt_res_t              res;
    logic                  step;

    logic [REPORT_BITS-1:0] sent_value;
    logic [REPORT_BITS-1:0] drop_value;
    logic [REPORT_BITS-1:0] fail_value;

    // Handshake: result register frees when empty or taken
    assign out_free  = !out_valid_reg || !out_stall;
    assign advance   = s1_valid_reg && out_free;
    assign in_stall  = s1_valid_reg && !out_free;
    assign in_take   = in_valid && !in_stall;
    assign step      = advance;
    assign cfg_ready = 1'b1;

    // Hold the input request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_item_reg <= '0;
        end
        else if (in_take)
        begin
            s1_item_reg <= in_data;
        end
    end

    // Decode the event against the current link state
    lsba_event u_event
    (
        .item          (s1_item_reg),
        .mode          (mode_reg),
        .backoff       (backoff_reg),
        .pending       (pending_reg),
        .admit_limit   (limit_reg),
        .max_backoff   (max_backoff_reg),
        .link_next     (link_next),
        .ctr_ctl       (ctr_ctl),
        .res           (res)
    );

    // Byte counters
    lsba_sat_ctr #(.COUNTER_BITS(COUNTER_BITS)) u_sent
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .add    (step && ctr_ctl.add_sent),
        .clear  (step && ctr_ctl.clear),
        .amount (s1_item_reg.byte_count),
        .value  (sent_value)
    );

    lsba_sat_ctr #(.COUNTER_BITS(COUNTER_BITS)) u_drop
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .add    (step && ctr_ctl.add_drop),
        .clear  (step && ctr_ctl.clear),
        .amount (s1_item_reg.byte_count),
        .value  (drop_value)
    );

    lsba_sat_ctr #(.COUNTER_BITS(COUNTER_BITS)) u_fail
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .add    (step && ctr_ctl.add_fail),
        .clear  (step && ctr_ctl.clear),
        .amount (s1_item_reg.byte_count),
        .value  (fail_value)
    );

    // Advance the link state on each processed request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_IDLE;
            backoff_reg <= DELAY_BITS'(1);
            pending_reg <= '0;
        end
        else if (step)
        begin
            mode_reg    <= link_next.mode;
            backoff_reg <= link_next.backoff;
            pending_reg <= link_next.pending;
        end
    end

    // Configuration registers; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg       <= PENDING_LIMIT_RST;
            max_backoff_reg <= MAX_BACKOFF_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_PENDING_LIMIT: limit_reg       <= cfg_data[BYTE_BITS-1:0];
                CFG_MAX_BACKOFF:   max_backoff_reg <= cfg_data[DELAY_BITS-1:0];
                default:           limit_reg       <= limit_reg;
            endcase
        end
    end

    // Assemble the result request
    always_comb
    begin
        out_item_next.link_state       = link_next.mode;
        out_item_next.command          = res.command;
        out_item_next.close_socket     = res.close_socket;
        out_item_next.arm_retry        = res.arm_retry;
        out_item_next.retry_delay_secs = res.retry_delay_secs;
        out_item_next.pending_total    = link_next.pending;
        out_item_next.report_valid     = res.report_valid;
        out_item_next.sent_total       = res.report_valid ? sent_value : '0;
        out_item_next.dropped_total    = res.report_valid ? drop_value : '0;
        out_item_next.failed_total     = res.report_valid ? fail_value : '0;
        out_item_next.start_error      = res.start_error;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= advance;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    // Checks
    `LSBA_ASSERT_IMPL(a_arm_in_wait, out_valid && out_data.arm_retry,
        out_data.link_state == MODE_WAIT, "retry armed outside retry wait")
    `LSBA_ASSERT_IMPL(a_backoff_nonzero, 1'b1, backoff_reg != '0,
        "reconnect delay reached zero")
    `LSBA_ASSERT_IMPL(a_totals_quiet, out_valid && !out_data.report_valid,
        (out_data.sent_total == '0) && (out_data.dropped_total == '0) &&
        (out_data.failed_total == '0), "counter totals without a report")
    `LSBA_ASSERT_NEXT(a_advance_lands, s1_valid_reg && out_free, out_valid_reg,
        "processed request missing from result register")

endmodule
